// ----- src/pal_pkg.sv -----
// Package for the positional array list: operation codes, controller states,
// cell command word and the fixed field widths. No dependencies.
`default_nettype none

package pal_pkg;

  localparam int DATA_W  = 32;  // width of one list entry
  localparam int POS_W   = 6;   // width of the position field
  localparam int LEN_W   = 6;   // width of the reported length
  localparam int GROUP_N = 32;  // cells folded by one first-level OR register

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GATHER
  } state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_DELETE
  } cell_cmd_t;

  // Broadcast to every cell: what to do this cycle and where (zero-based).
  typedef struct packed {
    cell_cmd_t           cmd;
    logic [POS_W-1:0]    slot;
    logic [DATA_W-1:0]   word;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/pal_cell.sv -----
// One storage cell of the list chain: holds one entry, takes its left or
// right neighbor on a shift, and drives its entry on the tap when selected.
// Depends on pal_pkg.
`default_nettype none

module pal_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 5
) (
  input  wire logic                         clk,
  input  wire pal_pkg::cell_ctl_t           ctl,
  input  wire logic [pal_pkg::DATA_W-1:0]   from_left,
  input  wire logic [pal_pkg::DATA_W-1:0]   from_right,
  output logic      [pal_pkg::DATA_W-1:0]   entry,
  output logic      [pal_pkg::DATA_W-1:0]   tap
);
  import pal_pkg::*;

  localparam int CW = IDX_W + POS_W;

  logic [CW-1:0] my_idx;
  logic [CW-1:0] slot_c;
  logic          at_slot;
  logic          above_slot;

  assign my_idx     = CW'(INDEX);
  assign slot_c     = CW'(ctl.slot);
  assign at_slot    = (my_idx == slot_c);
  assign above_slot = (my_idx > slot_c);

  // Drive the entry only when this cell sits at the addressed slot.
  assign tap = {DATA_W{at_slot}} & entry;

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_INSERT: begin
        if (at_slot) begin
          entry <= ctl.word;
        end else if (above_slot) begin
          entry <= from_left;
        end
      end
      CMD_DELETE: begin
        if (at_slot || above_slot) begin
          entry <= from_right;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/positional_array_list_top.sv -----
// Top level of the positional array list: controller, length counter, the
// chain of pal_cell storage cells and the two-level read-out OR tree.
// Depends on pal_pkg and pal_cell.
`default_nettype none

// Positional array list. Each word taken on start (while busy is low) carries
// an op (clear, insert, delete, read), a one-based position and a value.
// Every word gives exactly one result, after the exec and gather states:
// done is high for one cycle with ok, item_out and list_length. The receiver
// cannot stall, so read the result in the cycle done is high. busy is high
// in the exec and gather states, so no new word is taken while one is in
// progress. The exec state applies the op to the cell chain (the cells at and
// above the slot shift in parallel) and folds the cell taps into groups of
// 32; the gather state folds the groups into the result word. A refused op
// (full, empty or bad position) gives ok low, item_out zero and the
// unchanged length.
module positional_array_list_top #(
  parameter int CAPACITY = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         op,
  input  wire logic [pal_pkg::POS_W-1:0]          position,
  input  wire logic signed [pal_pkg::DATA_W-1:0]  value,
  output logic                                    done,
  output logic                                    ok,
  output logic signed [pal_pkg::DATA_W-1:0]       item_out,
  output logic      [pal_pkg::LEN_W-1:0]          list_length
);
  import pal_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int NG    = (CAPACITY + GROUP_N - 1) / GROUP_N;

  // Controller state and the held input word.
  state_t            state;
  state_t            state_next;
  op_t               op_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              ok_r;
  logic              take_r;

  logic accept;
  logic exec_en;
  logic gather_en;

  assign accept = start && !busy;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_EXEC;
      ST_EXEC:   state_next = ST_GATHER;
      ST_GATHER: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    busy      = 1'b0;
    exec_en   = 1'b0;
    gather_en = 1'b0;
    case (state)
      ST_IDLE:   busy = 1'b0;
      ST_EXEC: begin
        busy    = 1'b1;
        exec_en = 1'b1;
      end
      ST_GATHER: begin
        busy      = 1'b1;
        gather_en = 1'b1;
      end
      default:   busy = 1'b0;
    endcase
  end

  // Range checks, done at a width that holds both the count and the position.
  logic [EW-1:0] cnt_e;
  logic [EW-1:0] pos_e;
  logic          full;
  logic          ins_ok;
  logic          rd_ok;
  logic          ok_exec;
  logic          take_exec;

  assign cnt_e  = EW'(count);
  assign pos_e  = EW'(pos_r);
  assign full   = (count == CNT_W'(CAPACITY));
  assign ins_ok = !full && (pos_r != '0) && (pos_e <= cnt_e + EW'(1));
  assign rd_ok  = (count != '0) && (pos_r != '0) && (pos_e <= cnt_e);

  cell_ctl_t ctl;

  always_comb begin
    ctl.cmd   = CMD_NONE;
    ctl.slot  = pos_r - POS_W'(1);
    ctl.word  = value_r;
    count_next = count;
    ok_exec    = 1'b0;
    take_exec  = 1'b0;
    case (op_r)
      OP_CLEAR: begin
        count_next = '0;
        ok_exec    = 1'b1;
      end
      OP_INSERT: begin
        if (ins_ok) begin
          ctl.cmd    = exec_en ? CMD_INSERT : CMD_NONE;
          count_next = count + CNT_W'(1);
          ok_exec    = 1'b1;
        end
      end
      OP_DELETE: begin
        if (rd_ok) begin
          ctl.cmd    = exec_en ? CMD_DELETE : CMD_NONE;
          count_next = count - CNT_W'(1);
          ok_exec    = 1'b1;
          take_exec  = 1'b1;
        end
      end
      OP_READ: begin
        if (rd_ok) begin
          ok_exec   = 1'b1;
          take_exec = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Cell chain: each cell sees its neighbors' entries; the ends see zero.
  logic [DATA_W-1:0] entry [CAPACITY];
  logic [DATA_W-1:0] tap_pad [NG*GROUP_N];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;
    if (i == 0) begin : g_l0
      assign left_w = '0;
    end else begin : g_ln
      assign left_w = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_r0
      assign right_w = '0;
    end else begin : g_rn
      assign right_w = entry[i+1];
    end
    pal_cell #(
      .INDEX (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_left  (left_w),
      .from_right (right_w),
      .entry      (entry[i]),
      .tap        (tap_pad[i])
    );
  end

  // Pad the tap row to whole groups with zero.
  for (genvar i = CAPACITY; i < NG*GROUP_N; i++) begin : g_pad
    assign tap_pad[i] = '0;
  end

  // First fold: one OR register per group of cells, loaded in the exec cycle
  // from the entries as they stood before the shift.
  logic [DATA_W-1:0] grp_or [NG];
  logic [DATA_W-1:0] grp_q  [NG];

  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_comb begin
      grp_or[g] = '0;
      for (int j = 0; j < GROUP_N; j++) begin
        grp_or[g] = grp_or[g] | tap_pad[g*GROUP_N + j];
      end
    end
    always_ff @(posedge clk) begin
      if (exec_en) begin
        grp_q[g] <= grp_or[g];
      end
    end
  end

  // Second fold across the group registers.
  logic [DATA_W-1:0] fold;

  always_comb begin
    fold = '0;
    for (int g = 0; g < NG; g++) begin
      fold = fold | grp_q[g];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= gather_en;
      if (exec_en) begin
        count <= count_next;
      end
    end
  end

  // Payload registers: hold the input word, the verdict and the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(op);
      pos_r   <= position;
      value_r <= value;
    end
    if (exec_en) begin
      ok_r   <= ok_exec;
      take_r <= take_exec;
    end
    if (gather_en) begin
      ok          <= ok_r;
      item_out    <= take_r ? fold : '0;
      list_length <= LEN_W'(count);
    end
  end

  // The length never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  // A taken word moves the controller into its exec cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted word did not start executing");

  // A result strobe follows a gather cycle and no other.
  a_done_after_gather: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_GATHER))
    else $error("result strobe without gather cycle");

  // A refused op reports a zero item.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (item_out == '0))
    else $error("refused op reported a nonzero item");

endmodule

`default_nettype wire
